[rtl/cas_pkg.sv]
// shared types and constants for the color alternating shortest path block
// no dependencies
package cas_pkg;

    localparam int NODE_BITS  = 6;
    localparam int NUM_NODES  = 1 << NODE_BITS;
    localparam int LEN_BITS   = 16;
    localparam int COLOR_BITS = 8;
    localparam int ADDR_BITS  = 2 * NODE_BITS;
    localparam int PATH_BITS  = 22;
    localparam int BEST_BITS  = PATH_BITS + 1;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    typedef struct packed {
        logic [LEN_BITS-1:0]   len;
        logic [COLOR_BITS-1:0] color;
    } edge_t;

    typedef struct packed {
        logic [NODE_BITS-1:0]  node;
        logic [NODE_BITS:0]    next;
        logic [COLOR_BITS-1:0] color;
        logic [PATH_BITS-1:0]  len;
    } frame_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WR2,
        S_SCAN,
        S_EVAL,
        S_POP,
        S_DONE
    } state_t;

endpackage

[rtl/cas_edge_store.sv]
// edge length and color table, one write port and one registered read port
// depends on cas_pkg
module cas_edge_store (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [cas_pkg::ADDR_BITS-1:0] wr_addr,
    input  cas_pkg::edge_t                wr_data,
    input  logic [cas_pkg::ADDR_BITS-1:0] rd_addr,
    output cas_pkg::edge_t                rd_data
);
    import cas_pkg::*;

    edge_t mem [0:(1 << ADDR_BITS)-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/color_alternating_shortest_path.sv]
// top level: request decode, clearing sweep, depth-first search sequencer
// depends on cas_pkg and cas_edge_store
//
// usage
// - request channel (in_valid/in_ready): req_type clear, write edge or query
// - result channel (out_valid/out_ready): one result per query only
// - config channel (cfg_valid/cfg_ready, data highest_node): always ready
// - after reset and after a clear request the edge table is swept, one
//   entry per cycle over all 4096 entries, with in_ready low
// - edge write: node_a,node_b then node_b,node_a via the single write port
// - query: depth-first search, each neighbor examined in SCAN then EVAL
//   and each backtrack in SCAN then POP; the one read port of the edge
//   table serialises the reads, so the run time is data dependent
// - source equal to destination answers through S_DONE with no search
// - the result sits in an output register; a stalled receiver holds it and
//   the next query waits at its end until the register is free
// - stack frames live in a 64 entry memory, the top frame in registers
module color_alternating_shortest_path (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     req_type,
    input  logic [cas_pkg::NODE_BITS-1:0]  node_a,
    input  logic [cas_pkg::NODE_BITS-1:0]  node_b,
    input  logic [cas_pkg::LEN_BITS-1:0]   edge_length,
    input  logic [cas_pkg::COLOR_BITS-1:0] edge_color,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           reachable,
    output logic [cas_pkg::PATH_BITS-1:0]  shortest_length,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cas_pkg::NODE_BITS-1:0]  highest_node
);
    import cas_pkg::*;

    state_t                 state_reg, state_next;
    logic [ADDR_BITS-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [ADDR_BITS-1:0]   wr2_addr_reg, wr2_addr_next;
    edge_t                  wr2_data_reg, wr2_data_next;
    logic [NODE_BITS-1:0]   limit_reg;
    logic [NODE_BITS-1:0]   dst_reg, dst_next;
    logic [NODE_BITS-1:0]   idx_reg, idx_next;
    logic [NODE_BITS-1:0]   depth_reg, depth_next;
    logic [NUM_NODES-1:0]   visited_reg, visited_next;
    frame_t                 cur_reg, cur_next;
    logic [BEST_BITS-1:0]   best_reg, best_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   reach_reg, reach_next;
    logic [PATH_BITS-1:0]   len_out_reg, len_out_next;

    logic                   edge_we;
    logic [ADDR_BITS-1:0]   edge_waddr;
    edge_t                  edge_wdata;
    logic [ADDR_BITS-1:0]   edge_raddr;
    edge_t                  edge_rdata;

    frame_t                 stack_mem [0:NUM_NODES-1];
    logic                   stack_we;
    logic [NODE_BITS-1:0]   stack_raddr;
    frame_t                 stack_rdata;

    logic                   accept;
    logic [BEST_BITS-1:0]   new_len;
    logic                   skip;

    cas_edge_store u_edge_store (
        .clk     (clk),
        .wr_en   (edge_we),
        .wr_addr (edge_waddr),
        .wr_data (edge_wdata),
        .rd_addr (edge_raddr),
        .rd_data (edge_rdata)
    );

    assign in_ready        = (state_reg == S_IDLE);
    assign accept          = in_valid & in_ready;
    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign reachable       = reach_reg;
    assign shortest_length = len_out_reg;

    assign new_len = {1'b0, cur_reg.len} + BEST_BITS'(edge_rdata.len);
    assign skip    = (edge_rdata.len == '0) || (edge_rdata.color == cur_reg.color)
                     || visited_reg[idx_reg] || (new_len > best_reg);

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        wr2_addr_next  = wr2_addr_reg;
        wr2_data_next  = wr2_data_reg;
        dst_next       = dst_reg;
        idx_next       = idx_reg;
        depth_next     = depth_reg;
        visited_next   = visited_reg;
        cur_next       = cur_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        reach_next     = reach_reg;
        len_out_next   = len_out_reg;
        edge_we        = 1'b0;
        edge_waddr     = clr_cnt_reg;
        edge_wdata     = '0;
        edge_raddr     = {cur_reg.node, cur_reg.next[NODE_BITS-1:0]};
        stack_we       = 1'b0;
        stack_raddr    = depth_reg - 1'b1;

        case (state_reg)
            S_CLEAR:
            begin
                edge_we      = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            state_next   = S_CLEAR;
                        end
                        REQ_WRITE:
                        begin
                            edge_we       = 1'b1;
                            edge_waddr    = {node_a, node_b};
                            edge_wdata    = '{len: edge_length, color: edge_color};
                            wr2_addr_next = {node_b, node_a};
                            wr2_data_next = '{len: edge_length, color: edge_color};
                            state_next    = S_WR2;
                        end
                        REQ_QUERY:
                        begin
                            dst_next     = node_b;
                            depth_next   = '0;
                            visited_next = '0;
                            visited_next[node_a] = 1'b1;
                            cur_next     = '{node: node_a, next: '0, color: '0, len: '0};
                            if (node_a == node_b)
                            begin
                                best_next  = '0;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                best_next  = '1;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WR2:
            begin
                edge_we    = 1'b1;
                edge_waddr = wr2_addr_reg;
                edge_wdata = wr2_data_reg;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (cur_reg.next > {1'b0, limit_reg})
                begin
                    visited_next[cur_reg.node] = 1'b0;
                    state_next = (depth_reg == '0) ? S_DONE : S_POP;
                end
                else
                begin
                    idx_next      = cur_reg.next[NODE_BITS-1:0];
                    cur_next.next = cur_reg.next + 1'b1;
                    state_next    = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_SCAN;
                if (!skip)
                begin
                    if (idx_reg == dst_reg)
                    begin
                        if (new_len < best_reg)
                        begin
                            best_next = new_len;
                        end
                    end
                    else if (depth_reg != NODE_BITS'(NUM_NODES - 1))
                    begin
                        stack_we   = 1'b1;
                        depth_next = depth_reg + 1'b1;
                        visited_next[idx_reg] = 1'b1;
                        cur_next   = '{node: idx_reg, next: '0, color: edge_rdata.color,
                                       len: new_len[PATH_BITS-1:0]};
                    end
                end
            end
            S_POP:
            begin
                cur_next   = stack_rdata;
                depth_next = depth_reg - 1'b1;
                state_next = S_SCAN;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    reach_next     = (best_reg != '1);
                    len_out_next   = (best_reg != '1) ? best_reg[PATH_BITS-1:0] : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            limit_reg     <= '1;
            depth_reg     <= '0;
            visited_reg   <= '0;
            best_reg      <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            depth_reg     <= depth_next;
            visited_reg   <= visited_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= highest_node;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr2_addr_reg <= wr2_addr_next;
        wr2_data_reg <= wr2_data_next;
        dst_reg      <= dst_next;
        idx_reg      <= idx_next;
        cur_reg      <= cur_next;
        reach_reg    <= reach_next;
        len_out_reg  <= len_out_next;
    end

    // frame stack, top frame kept in cur_reg
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[depth_reg] <= cur_reg;
        end
        stack_rdata <= stack_mem[stack_raddr];
    end

    a_eval_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVAL |-> $past(state_reg) == S_SCAN)
        else $error("edge evaluated without a preceding read");

    a_best_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVAL |=> best_reg <= $past(best_reg))
        else $error("best length grew during search");

    a_top_visited: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> visited_reg[cur_reg.node])
        else $error("top frame node not marked visited");

endmodule
